### rtl/core/ppf_pkg.sv
`default_nettype none

package ppf_pkg;

   // Port widths fixed by the stream format
   localparam int SYM_PORT_W  = 8;
   localparam int KIND_W      = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int PLEN_W      = 4;
   localparam int PADN_W      = 6;

   // Output item tags
   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_DATA     = 2'd0;
   localparam kind_type KIND_PREAMBLE = 2'd1;
   localparam kind_type KIND_PADDING  = 2'd2;

   // Register map
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_PREAMBLE_SYMBOLS = 2'd0;
   localparam csr_index_type CSR_PREAMBLE_LENGTH  = 2'd1;
   localparam csr_index_type CSR_PADDING_LENGTH   = 2'd2;
   localparam csr_index_type CSR_END_ENABLE       = 2'd3;

endpackage

`default_nettype wire

### rtl/core/preamble_padding_framer_top.sv
`default_nettype none

// Preamble/padding framer. Each accepted symbol produces one output per cycle
// while rsp_stall is low: when start_flag is set, preamble_length preamble
// symbols (clamped to 1..MAX_PREAMBLE; the first carries start_mark) precede
// it; when end_flag is set and end_enable is 1, padding_length (clamped to
// MAX_PADDING) zero symbols follow it, the last one carrying end_mark (the
// data symbol carries it when padding_length is zero). last_of_run marks the
// final output of each input symbol. The single output sequencer emits one
// item per cycle while rsp_stall is low; plain data symbols stream at one per
// cycle under the same condition. The next symbol is taken in the cycle the
// current one emits its last output, and an output register decouples the
// result side. Configuration is sampled live and must be written while idle.
module preamble_padding_framer_top #(
   parameter int SYMBOL_BITS  = 8,
   parameter int MAX_PREAMBLE = 8,
   parameter int MAX_PADDING  = 55
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // configuration write port
   input  wire                                 csr_write_enable,
   input  wire  [ppf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [ppf_pkg::CSR_DATA_W-1:0]      csr_data,
   // input symbol channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [ppf_pkg::SYM_PORT_W-1:0]      req_symbol_in,
   input  wire                                 req_start_flag,
   input  wire                                 req_end_flag,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [ppf_pkg::SYM_PORT_W-1:0]      rsp_symbol_out,
   output logic [ppf_pkg::KIND_W-1:0]          rsp_item_kind,
   output logic                                rsp_start_mark,
   output logic                                rsp_end_mark,
   output logic                                rsp_last_of_run
);

   localparam int CNT_MAX = (MAX_PREAMBLE > MAX_PADDING) ? MAX_PREAMBLE : MAX_PADDING;
   localparam int IDX_W   = (CNT_MAX < 2) ? 1 : $clog2(CNT_MAX + 1);

   // sequencer phase codes
   localparam logic [1:0] PH_PRE  = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_PAD  = 2'd2;

   // configuration registers
   logic [ppf_pkg::CSR_DATA_W-1:0] preamble_ff, preamble_in;
   logic [ppf_pkg::PLEN_W-1:0]     plen_ff, plen_in;
   logic [ppf_pkg::PADN_W-1:0]     padn_ff, padn_in;
   logic                           end_en_ff, end_en_in;

   // held input item and sequencer position
   logic                   item_valid_ff, item_valid_in;
   logic [SYMBOL_BITS-1:0] item_sym_ff, item_sym_in;
   logic                   item_start_ff, item_start_in;
   logic                   item_end_ff, item_end_in;
   logic [1:0]             phase_ff, phase_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ppf_pkg::SYM_PORT_W-1:0] rsp_sym_ff, rsp_sym_in;
   ppf_pkg::kind_type              rsp_kind_ff, rsp_kind_in;
   logic                           rsp_smark_ff, rsp_smark_in;
   logic                           rsp_emark_ff, rsp_emark_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           req_accept;
   logic                           load;
   logic                           done;
   logic [ppf_pkg::PLEN_W-1:0]     plen_eff;
   logic [ppf_pkg::PADN_W-1:0]     padn_eff;
   logic                           end_eff;
   logic [IDX_W-1:0]               idx_next;
   logic [ppf_pkg::CSR_DATA_W-1:0] pre_shift;
   logic [ppf_pkg::SYM_PORT_W-1:0] cur_sym;
   ppf_pkg::kind_type              cur_kind;
   logic                           cur_smark;
   logic                           cur_emark;
   logic                           cur_last;
   logic [1:0]                     adv_phase;
   logic [IDX_W-1:0]               adv_idx;

   // configuration writes
   always_comb begin
      preamble_in = preamble_ff;
      plen_in     = plen_ff;
      padn_in     = padn_ff;
      end_en_in   = end_en_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ppf_pkg::CSR_PREAMBLE_SYMBOLS: preamble_in = csr_data;
            ppf_pkg::CSR_PREAMBLE_LENGTH:  plen_in     = csr_data[ppf_pkg::PLEN_W-1:0];
            ppf_pkg::CSR_PADDING_LENGTH:   padn_in     = csr_data[ppf_pkg::PADN_W-1:0];
            ppf_pkg::CSR_END_ENABLE:       end_en_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   // effective lengths after clamping
   always_comb begin
      if (plen_ff == '0) begin
         plen_eff = ppf_pkg::PLEN_W'(1);
      end else if (plen_ff > ppf_pkg::PLEN_W'(MAX_PREAMBLE)) begin
         plen_eff = ppf_pkg::PLEN_W'(MAX_PREAMBLE);
      end else begin
         plen_eff = plen_ff;
      end
      if (padn_ff > ppf_pkg::PADN_W'(MAX_PADDING)) begin
         padn_eff = ppf_pkg::PADN_W'(MAX_PADDING);
      end else begin
         padn_eff = padn_ff;
      end
   end

   assign end_eff   = item_end_ff & end_en_ff;
   assign idx_next  = idx_ff + 1'b1;
   assign pre_shift = preamble_ff >> (idx_ff * SYMBOL_BITS);

   // current output item and next sequencer position
   always_comb begin
      cur_sym   = '0;
      cur_kind  = ppf_pkg::KIND_DATA;
      cur_smark = 1'b0;
      cur_emark = 1'b0;
      cur_last  = 1'b0;
      adv_phase = phase_ff;
      adv_idx   = idx_ff;
      case (phase_ff)
         PH_PRE: begin
            cur_sym[SYMBOL_BITS-1:0] = pre_shift[SYMBOL_BITS-1:0];
            cur_kind  = ppf_pkg::KIND_PREAMBLE;
            cur_smark = (idx_ff == '0);
            if (idx_next == plen_eff) begin
               adv_phase = PH_DATA;
               adv_idx   = '0;
            end else begin
               adv_idx = idx_next;
            end
         end
         PH_DATA: begin
            cur_sym[SYMBOL_BITS-1:0] = item_sym_ff;
            cur_kind  = ppf_pkg::KIND_DATA;
            cur_emark = end_eff && (padn_eff == '0);
            cur_last  = !(end_eff && (padn_eff != '0));
            adv_phase = PH_PAD;
            adv_idx   = '0;
         end
         PH_PAD: begin
            cur_kind  = ppf_pkg::KIND_PADDING;
            cur_emark = (idx_next == padn_eff);
            cur_last  = cur_emark;
            adv_idx   = idx_next;
         end
         default: begin
            cur_last = 1'b1;
         end
      endcase
   end

   // handshake
   assign load       = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign done       = load && cur_last;
   assign req_stall  = item_valid_ff && !done;
   assign req_accept = req_valid && !req_stall;

   // item slot and sequencer
   always_comb begin
      item_valid_in = item_valid_ff;
      item_sym_in   = item_sym_ff;
      item_start_in = item_start_ff;
      item_end_in   = item_end_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
         item_sym_in   = req_symbol_in[SYMBOL_BITS-1:0];
         item_start_in = req_start_flag;
         item_end_in   = req_end_flag;
         phase_in      = req_start_flag ? PH_PRE : PH_DATA;
         idx_in        = '0;
      end else if (done) begin
         item_valid_in = 1'b0;
      end else if (load) begin
         phase_in = adv_phase;
         idx_in   = adv_idx;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_smark_in = rsp_smark_ff;
      rsp_emark_in = rsp_emark_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = cur_sym;
         rsp_kind_in  = cur_kind;
         rsp_smark_in = cur_smark;
         rsp_emark_in = cur_emark;
         rsp_last_in  = cur_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff   <= ppf_pkg::CSR_DATA_W'(1);
         plen_ff       <= ppf_pkg::PLEN_W'(1);
         padn_ff       <= '0;
         end_en_ff     <= 1'b0;
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_DATA;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         preamble_ff   <= preamble_in;
         plen_ff       <= plen_in;
         padn_ff       <= padn_in;
         end_en_ff     <= end_en_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      item_sym_ff   <= item_sym_in;
      item_start_ff <= item_start_in;
      item_end_ff   <= item_end_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_smark_ff  <= rsp_smark_in;
      rsp_emark_ff  <= rsp_emark_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_out  = rsp_sym_ff;
   assign rsp_item_kind   = rsp_kind_ff;
   assign rsp_start_mark  = rsp_smark_ff;
   assign rsp_end_mark    = rsp_emark_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTHESIS
   // an item stays held until its last output is loaded
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !done && !req_accept) |=> item_valid_ff)
      else $error("item slot dropped before its last output");

   // padding phase only reached for enabled frame ends with padding
   a_pad_phase: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && phase_ff == PH_PAD) |-> (end_eff && padn_eff != '0))
      else $error("padding phase without an enabled frame end");

   // preamble index stays inside the configured length
   a_pre_idx: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && phase_ff == PH_PRE) |-> (idx_ff < plen_eff))
      else $error("preamble index out of range");

   // start mark only on a preamble item, never with last_of_run
   a_smark_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_smark_ff) |->
         (rsp_kind_ff == ppf_pkg::KIND_PREAMBLE && !rsp_last_ff))
      else $error("start mark on a non-preamble output");
`endif

endmodule

`default_nettype wire
